[rtl/odt_pkg.sv]
// ----------------------------------------------------------------------------
// odt_pkg
// Shared types and constants for the on/off delay timer bank: request and
// result payloads, per-channel state entry and operation codes.
// ----------------------------------------------------------------------------
package odt_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int CHAN_EXT_W   = 9;
	localparam int STAMP_W      = 48;
	localparam int ELAPSED_W    = 34;
	localparam int PRESET_W     = 24;
	localparam int CHAN_W       = 4;
	localparam int FUNC_W       = 2;
	localparam int SCALE_W      = 10;

	localparam logic [SCALE_W-1:0] US_PER_MS = 10'd1000;

	localparam logic [FUNC_W-1:0] FUNC_ON    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_OFF   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [CHAN_W-1:0]   channel;
		logic                condition;
		logic [PRESET_W-1:0] preset_ms;
		logic [STAMP_W-1:0]  now_us;
	} req_t;

	typedef struct packed {
		logic                 q_out;
		logic [ELAPSED_W-1:0] elapsed_us;
		logic                 running_out;
	} res_t;

	typedef struct packed {
		logic [STAMP_W-1:0]   start_stamp;
		logic                 timing_flag;
		logic                 output_bit;
		logic [ELAPSED_W-1:0] elapsed_store;
		logic                 clear_prev;
	} entry_t;

endpackage

[rtl/odt_ram.sv]
// ----------------------------------------------------------------------------
// odt_ram
// Channel state memory: one write port, one registered read port. A valid
// bit per entry makes entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module odt_ram #(
	parameter int DEPTH = odt_pkg::CHANNELS_DEF,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output odt_pkg::entry_t       rdata,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  odt_pkg::entry_t       wdata
);

	odt_pkg::entry_t mem [DEPTH];
	odt_pkg::entry_t rd_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

[rtl/odt_calc.sv]
// ----------------------------------------------------------------------------
// odt_calc
// Next-state logic for one timer channel: on-delay, off-delay and clear on
// rising condition, applied to the entry read from the state memory.
// ----------------------------------------------------------------------------
module odt_calc (
	input  logic [odt_pkg::FUNC_W-1:0]    func,
	input  logic                          cond,
	input  logic [odt_pkg::STAMP_W-1:0]   now,
	input  logic [odt_pkg::ELAPSED_W-1:0] limit,
	input  odt_pkg::entry_t               cur,
	output odt_pkg::entry_t               nxt
);

	logic                          start;
	logic [odt_pkg::STAMP_W-1:0]   stamp;
	logic                          timing;
	logic [odt_pkg::STAMP_W-1:0]   diff;
	logic                          over;
	logic [odt_pkg::ELAPSED_W-1:0] el_t;
	logic                          zero_pre;

	always_comb begin
		zero_pre = (limit == '0);
		start    = 1'b0;
		case (func)
			odt_pkg::FUNC_ON:  start = !cur.timing_flag && !cur.output_bit;
			odt_pkg::FUNC_OFF: start = !cur.timing_flag && cur.output_bit;
			default:           start = 1'b0;
		endcase
		stamp  = start ? now : cur.start_stamp;
		timing = cur.timing_flag || start;
		diff   = now - stamp;
		over   = diff > {{(odt_pkg::STAMP_W-odt_pkg::ELAPSED_W){1'b0}}, limit};
		el_t   = over ? limit : diff[odt_pkg::ELAPSED_W-1:0];
	end

	always_comb begin
		nxt = cur;
		case (func)
			odt_pkg::FUNC_ON: begin
				if (zero_pre || !cond) begin
					nxt.elapsed_store = '0;
					nxt.output_bit    = 1'b0;
					nxt.timing_flag   = 1'b0;
				end else begin
					nxt.start_stamp = stamp;
					if (timing) begin
						nxt.timing_flag   = !over;
						nxt.elapsed_store = el_t;
						nxt.output_bit    = (el_t >= limit);
					end else begin
						nxt.timing_flag   = 1'b0;
						nxt.elapsed_store = limit;
						nxt.output_bit    = 1'b1;
					end
				end
			end
			odt_pkg::FUNC_OFF: begin
				if (zero_pre || cond) begin
					nxt.elapsed_store = '0;
					nxt.output_bit    = cond;
					nxt.timing_flag   = 1'b0;
				end else begin
					nxt.start_stamp = stamp;
					if (timing) begin
						nxt.timing_flag   = !over;
						nxt.elapsed_store = el_t;
						nxt.output_bit    = (el_t < limit);
					end else if (!cur.output_bit) begin
						nxt.elapsed_store = '0;
					end
				end
			end
			odt_pkg::FUNC_CLEAR: begin
				nxt.clear_prev = cond;
				if (cond && !cur.clear_prev) begin
					nxt.elapsed_store = '0;
					nxt.output_bit    = 1'b0;
					nxt.timing_flag   = 1'b0;
				end
			end
			default: nxt = cur;
		endcase
	end

endmodule

[rtl/on_off_delay_timer_bank.sv]
// ----------------------------------------------------------------------------
// on_off_delay_timer_bank
// Bank of on-delay / off-delay timer channels with state held in a memory,
// updated by read-modify-write, one result per request.
//
//   channel  valid      stall      payload  role
//   req      req_valid  req_stall  req      timer request in
//   res      res_valid  res_stall  res      channel status out
//
// each request goes through memory read and preset scaling, then update and
// write back; no new request is taken until the last leaves the update stage
// the result sits in an output register, so a request can be taken while the
// previous result is stalled; a request then waits in the update stage
// reset clears per-entry valid bits at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module on_off_delay_timer_bank #(
	parameter int CHANNELS = odt_pkg::CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  odt_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output odt_pkg::res_t res
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [odt_pkg::CHAN_EXT_W-1:0] chan_ext;
	logic                           in_range;
	logic                           accept;
	logic                           done;

	logic                          s1_valid_q;
	logic [odt_pkg::FUNC_W-1:0]    func_s1;
	logic                          cond_s1;
	logic [odt_pkg::STAMP_W-1:0]   now_s1;
	logic [odt_pkg::ELAPSED_W-1:0] limit_s1;
	logic                          inr_s1;
	logic [AW-1:0]                 addr_s1;

	odt_pkg::entry_t cur;
	odt_pkg::entry_t nxt;

	logic          res_valid_q;
	odt_pkg::res_t res_q;

	assign chan_ext  = {{(odt_pkg::CHAN_EXT_W-odt_pkg::CHAN_W){1'b0}}, req.channel};
	assign in_range  = chan_ext < odt_pkg::CHAN_EXT_W'(CHANNELS);
	assign req_stall = s1_valid_q;
	assign accept    = req_valid && !s1_valid_q;
	assign done      = s1_valid_q && (!res_valid_q || !res_stall);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= req.func;
			cond_s1  <= req.condition;
			now_s1   <= req.now_us;
			limit_s1 <= odt_pkg::ELAPSED_W'(
				{{(odt_pkg::ELAPSED_W-odt_pkg::PRESET_W){1'b0}}, req.preset_ms}
				* {{(odt_pkg::ELAPSED_W-odt_pkg::SCALE_W){1'b0}}, odt_pkg::US_PER_MS});
			inr_s1   <= in_range;
			addr_s1  <= chan_ext[AW-1:0];
		end
	end

	odt_ram #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept),
		.raddr  (chan_ext[AW-1:0]),
		.rdata  (cur),
		.we     (done && inr_s1),
		.waddr  (addr_s1),
		.wdata  (nxt)
	);

	odt_calc u_calc (
		.func  (func_s1),
		.cond  (cond_s1),
		.now   (now_s1),
		.limit (limit_s1),
		.cur   (cur),
		.nxt   (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (inr_s1) begin
				res_q.q_out       <= nxt.output_bit;
				res_q.elapsed_us  <= nxt.elapsed_store;
				res_q.running_out <= nxt.timing_flag;
			end else begin
				res_q <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted request did not enter update stage");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(s1_valid_q))
		else $error("result appeared without a request in update stage");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall && !done |=> $stable(res_q))
		else $error("stalled result changed");

	a_elapsed_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && inr_s1
		&& (func_s1 == odt_pkg::FUNC_ON || func_s1 == odt_pkg::FUNC_OFF)
		|-> nxt.elapsed_store <= limit_s1)
		else $error("elapsed time beyond preset");
`endif

endmodule

[bench/on_off_delay_timer_bank_tb.sv]
// ----------------------------------------------------------------------------
// on_off_delay_timer_bank_tb
// Self-checking bench for the timer bank. A short directed sequence covers
// zero presets, expiry at and beyond the preset, edge-triggered clears, the
// unused operation code and stamp wrap-around. Random rungs then run each
// channel as an on-delay or off-delay timer against an advancing microsecond
// clock, mixed with clears and raw noise. A scoreboard predicts each channel
// status and compares it field by field. Both sides idle in random bursts,
// and the receiver holds off once long enough to back up the request side.
// ----------------------------------------------------------------------------
module on_off_delay_timer_bank_tb;

	localparam logic [odt_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 1250;
	localparam int QUIET_FROM   = 1100;
	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;

	class channel_status_board;
		bit [odt_pkg::STAMP_W-1:0]   ch_start   [odt_pkg::CHANNELS_DEF];
		bit                          ch_run     [odt_pkg::CHANNELS_DEF];
		bit                          ch_q       [odt_pkg::CHANNELS_DEF];
		bit [odt_pkg::ELAPSED_W-1:0] ch_elapsed [odt_pkg::CHANNELS_DEF];
		bit                          ch_prev    [odt_pkg::CHANNELS_DEF];
		odt_pkg::res_t               status_due [$];
		int                          mismatches;

		function odt_pkg::res_t next_status(odt_pkg::req_t r);
			bit [odt_pkg::ELAPSED_W-1:0] lim;
			bit [odt_pkg::STAMP_W-1:0]   span;
			bit                          rise;
			int                          c;
			odt_pkg::res_t               s;
			c = int'(r.channel);
			lim = 34'(r.preset_ms) * 34'(odt_pkg::US_PER_MS);
			case (r.func)
			odt_pkg::FUNC_ON: begin
				if (r.preset_ms == '0 || !r.condition) begin
					ch_elapsed[c] = '0;
					ch_q[c] = 1'b0;
					ch_run[c] = 1'b0;
				end else begin
					if (!ch_run[c] && !ch_q[c]) begin
						ch_start[c] = r.now_us;
						ch_run[c] = 1'b1;
					end
					if (ch_run[c]) begin
						span = r.now_us - ch_start[c];
						if (span > 48'(lim)) begin
							span = 48'(lim);
							ch_run[c] = 1'b0;
						end
						ch_elapsed[c] = span[odt_pkg::ELAPSED_W-1:0];
						ch_q[c] = (span >= 48'(lim));
					end else begin
						ch_elapsed[c] = lim;
						ch_q[c] = 1'b1;
					end
				end
			end
			odt_pkg::FUNC_OFF: begin
				if (r.preset_ms == '0 || r.condition) begin
					ch_elapsed[c] = '0;
					ch_q[c] = r.condition;
					ch_run[c] = 1'b0;
				end else begin
					if (!ch_run[c] && ch_q[c]) begin
						ch_start[c] = r.now_us;
						ch_run[c] = 1'b1;
					end
					if (ch_run[c]) begin
						span = r.now_us - ch_start[c];
						if (span > 48'(lim)) begin
							span = 48'(lim);
							ch_run[c] = 1'b0;
						end
						ch_elapsed[c] = span[odt_pkg::ELAPSED_W-1:0];
						ch_q[c] = (span < 48'(lim));
					end else if (!ch_q[c]) begin
						ch_elapsed[c] = '0;
					end
				end
			end
			odt_pkg::FUNC_CLEAR: begin
				rise = r.condition && !ch_prev[c];
				ch_prev[c] = r.condition;
				if (rise) begin
					ch_elapsed[c] = '0;
					ch_q[c] = 1'b0;
					ch_run[c] = 1'b0;
				end
			end
			default: ;
			endcase
			s.q_out = ch_q[c];
			s.elapsed_us = ch_elapsed[c];
			s.running_out = ch_run[c];
			return s;
		endfunction

		function void note_request(odt_pkg::req_t r);
			status_due.push_back(next_status(r));
		endfunction

		function void check_status(odt_pkg::res_t got);
			odt_pkg::res_t want;
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("status with no request pending: q=%0d el=%0d run=%0d",
						got.q_out, got.elapsed_us, got.running_out);
				return;
			end
			want = status_due.pop_front();
			if (got.q_out !== want.q_out || got.elapsed_us !== want.elapsed_us ||
					got.running_out !== want.running_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display("status mismatch: exp q=%0d el=%0d run=%0d, got q=%0d el=%0d run=%0d",
						want.q_out, want.elapsed_us, want.running_out,
						got.q_out, got.elapsed_us, got.running_out);
			end
		endfunction

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	odt_pkg::req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	odt_pkg::res_t res;

	channel_status_board board = new();

	bit quiet = 1'b0;
	bit hold_off_req = 1'b0;
	int res_hold_pct = 0;
	int req_gap_pct = 0;
	int idle_cycles = 0;

	logic [odt_pkg::STAMP_W-1:0]  wall_us;
	logic [odt_pkg::FUNC_W-1:0]   rung_kind   [odt_pkg::CHANNELS_DEF];
	logic                         rung_cond   [odt_pkg::CHANNELS_DEF];
	logic [odt_pkg::PRESET_W-1:0] rung_preset [odt_pkg::CHANNELS_DEF];

	on_off_delay_timer_bank dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				board.note_request(req);
				moved = 1'b1;
			end
			if (res_valid && !res_stall) begin
				board.check_status(res);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("on_off_delay_timer_bank test failed");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_off_req = 1'b0;
				res_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < res_hold_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	function automatic odt_pkg::req_t timer_req(logic [odt_pkg::FUNC_W-1:0] f,
			logic [odt_pkg::CHAN_W-1:0] c, logic cnd,
			logic [odt_pkg::PRESET_W-1:0] p, logic [odt_pkg::STAMP_W-1:0] t);
		odt_pkg::req_t r;
		r.func = f;
		r.channel = c;
		r.condition = cnd;
		r.preset_ms = p;
		r.now_us = t;
		return r;
	endfunction

	function automatic odt_pkg::req_t next_rung_request();
		logic [95:0] raw;
		int          c;
		int          pick;
		c = $urandom_range(0, odt_pkg::CHANNELS_DEF - 1);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			raw = {$urandom, $urandom, $urandom};
			return raw[$bits(odt_pkg::req_t)-1:0];
		end
		case ($urandom_range(0, 3))
		0: wall_us += 48'(500 * $urandom_range(0, 4));
		1: wall_us += 48'($urandom_range(0, 3000));
		2: wall_us += 48'd1;
		default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			rung_cond[c] = ~rung_cond[c];
		if ($urandom_range(0, 99) == 0)
			rung_kind[c] = (rung_kind[c] == odt_pkg::FUNC_ON) ?
				odt_pkg::FUNC_OFF : odt_pkg::FUNC_ON;
		if ($urandom_range(0, 29) == 0) begin
			case ($urandom_range(0, 7))
			0: rung_preset[c] = '0;
			1: rung_preset[c] = odt_pkg::PRESET_W'($urandom);
			default: rung_preset[c] = odt_pkg::PRESET_W'($urandom_range(1, 4));
			endcase
		end
		if (pick < 84)
			return timer_req(rung_kind[c], odt_pkg::CHAN_W'(c), rung_cond[c],
				rung_preset[c], wall_us);
		if (pick < 93)
			return timer_req(odt_pkg::FUNC_CLEAR, odt_pkg::CHAN_W'(c), rung_cond[c],
				rung_preset[c], wall_us);
		if (pick < 96)
			return timer_req(FUNC_NONE, odt_pkg::CHAN_W'(c), rung_cond[c],
				rung_preset[c], wall_us);
		return timer_req(
			(rung_kind[c] == odt_pkg::FUNC_ON) ? odt_pkg::FUNC_OFF : odt_pkg::FUNC_ON,
			odt_pkg::CHAN_W'(c), rung_cond[c], rung_preset[c], wall_us);
	endfunction

	task automatic send_request(odt_pkg::req_t r);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic pause_sender(int n);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain_sender();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int pcts [5] = '{0, 0, 15, 40, 70};
		wall_us = 48'hFFFF_FFF0_0000;
		for (int i = 0; i < odt_pkg::CHANNELS_DEF; i++) begin
			rung_kind[i] = $urandom_range(0, 1) ? odt_pkg::FUNC_ON : odt_pkg::FUNC_OFF;
			rung_cond[i] = 1'b0;
			rung_preset[i] = odt_pkg::PRESET_W'($urandom_range(1, 4));
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// zero presets
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd0, 1'b1, 24'd0, 48'd100));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd1, 1'b1, 24'd0, 48'd100));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd1, 1'b0, 24'd0, 48'd200));
		// on-delay reaching and passing the preset
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd2, 1'b1, 24'd2, 48'd1000));
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd2, 1'b1, 24'd2, 48'd3000));
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd2, 1'b1, 24'd2, 48'd3001));
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd2, 1'b1, 24'd2, 48'd9000));
		// off-delay at exact preset then beyond
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd3, 1'b1, 24'd1, 48'd1000));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd3, 1'b0, 24'd1, 48'd2000));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd3, 1'b0, 24'd1, 48'd3000));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd3, 1'b0, 24'd1, 48'd3001));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd3, 1'b0, 24'd1, 48'd5000));
		// clears with and without a rising condition
		send_request(timer_req(odt_pkg::FUNC_CLEAR, 4'd2, 1'b0, 24'd0, 48'd9100));
		send_request(timer_req(odt_pkg::FUNC_CLEAR, 4'd2, 1'b1, 24'd0, 48'd9200));
		send_request(timer_req(odt_pkg::FUNC_CLEAR, 4'd2, 1'b1, 24'd0, 48'd9300));
		send_request(timer_req(FUNC_NONE, 4'd3, 1'b1, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF));
		// full preset across the stamp wrap
		send_request(timer_req(odt_pkg::FUNC_ON, 4'd15, 1'b1, 24'hFF_FFFF,
			48'hFFFF_FFFF_FFF0));
		send_request(timer_req(odt_pkg::FUNC_ON, 4'd15, 1'b1, 24'hFF_FFFF,
			48'h0000_0000_0010));
		send_request(timer_req(odt_pkg::FUNC_ON, 4'd15, 1'b1, 24'hFF_FFFF,
			48'hFFFF_FFFF_FFEF));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd15, 1'b0, 24'hFF_FFFF,
			48'h0000_0000_0000));
		send_request(timer_req(odt_pkg::FUNC_OFF, 4'd15, 1'b0, 24'hFF_FFFF,
			48'hFFFF_FFFF_FFFF));
		send_request(timer_req(odt_pkg::FUNC_ON,  4'd8,  1'b0, 24'd5, 48'h0000_0000_0005));
		drain_sender();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 125 == 0) begin
				res_hold_pct = pcts[$urandom_range(0, 4)];
				req_gap_pct = pcts[$urandom_range(0, 4)];
			end
			if (n == QUIET_FROM) begin
				quiet = 1'b1;
				res_hold_pct = 0;
				req_gap_pct = 0;
			end
			if (n == 400)
				hold_off_req = 1'b1;
			if (n == 750)
				drain_sender();
			send_request(next_rung_request());
			if (!quiet && $urandom_range(0, 99) < req_gap_pct)
				pause_sender($urandom_range(1, 15));
		end

		drain_sender();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("on_off_delay_timer_bank test passed");
		end else begin
			$display("on_off_delay_timer_bank test failed");
		end
		$finish;
	end

endmodule
